FILE: rtl/olkd_pkg.sv
package olkd_pkg;

  localparam int CAPACITY = 16;
  localparam int CntW     = $clog2(CAPACITY + 1);
  localparam int IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DataW    = 32;

  // command codes
  localparam logic [2:0] MODE_APPEND   = 3'd0;
  localparam logic [2:0] MODE_POP_HEAD = 3'd1;
  localparam logic [2:0] MODE_POP_TAIL = 3'd2;
  localparam logic [2:0] MODE_DEL_KEY  = 3'd3;
  localparam logic [2:0] MODE_DUMP     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // per-cell update
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_NEXT,
    CELL_TAKE_HEAD
  } cell_op_e;

endpackage

FILE: rtl/olkd_cell.sv
module olkd_cell
  import olkd_pkg::*;
(
  input  logic             clk_i,
  input  cell_op_e         op_i,
  input  logic [DataW-1:0] load_data_i,
  input  logic [DataW-1:0] next_data_i,
  input  logic [DataW-1:0] head_data_i,
  input  logic [DataW-1:0] key_i,
  output logic [DataW-1:0] data_o,
  output logic             match_o
);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  always_comb begin
    case (op_i)
      CELL_LOAD:      data_d = load_data_i;
      CELL_TAKE_NEXT: data_d = next_data_i;
      CELL_TAKE_HEAD: data_d = head_data_i;
      default:        data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule

FILE: rtl/ordered_list_with_keyed_delete.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells.
// Append, pop head/tail, key or dump on an empty list: result the next cycle, not busy.
// Remove by key otherwise: busy in the key state, result registered (match, shift).
// Dump of N entries: N results on consecutive cycles, registered from the dump state,
// busy in the dump state (one cell rotation per result). Results cannot be stalled.
// Reset (async, active low) empties the list; cell contents are not cleared.
module ordered_list_with_keyed_delete
  import olkd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] operand_value_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] entry_value_o,
  output logic               last_flag_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_DUMP
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     dump_idx_q, dump_idx_d;
  logic [CAPACITY-1:0] match_q, match_d;
  logic [DataW-1:0]    key_q, key_d;

  logic                valid_q, valid_d;
  logic [1:0]          status_q, status_d;
  logic [DataW-1:0]    value_q, value_d;
  logic                last_q, last_d;

  // cell row
  cell_op_e            cell_op   [CAPACITY];
  logic [DataW-1:0]    cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] occupied;

  logic                take;
  logic [CAPACITY-1:0] first_hit;
  logic [CAPACITY-1:0] shift_mask;

  assign take = start && !busy;
  assign busy = (state_q != ST_IDLE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] next_data;

    if (i == CAPACITY - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    olkd_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op[i]),
      .load_data_i (operand_value_i),
      .next_data_i (next_data),
      .head_data_i (cell_data[0]),
      .key_i       (operand_value_i),
      .data_o      (cell_data[i]),
      .match_o     (cell_match[i])
    );

    assign occupied[i] = (CntW'(i) < count_q);
  end

  // lowest matching cell, and every cell from it upward closes the gap
  assign first_hit  = match_q & (~match_q + CAPACITY'(1));
  assign shift_mask = ~(first_hit - CAPACITY'(1));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    dump_idx_d = dump_idx_q;
    match_d    = match_q;
    key_d      = key_q;
    valid_d    = 1'b0;
    status_d   = STAT_OK;
    value_d    = '0;
    last_d     = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = CELL_HOLD;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (mode_i)
            MODE_APPEND: begin
              valid_d = 1'b1;
              if (count_q == CntW'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CntW'(i) == count_q) cell_op[i] = CELL_LOAD;
                end
                count_d = count_q + CntW'(1);
              end
            end
            MODE_POP_HEAD: begin
              valid_d = 1'b1;
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                value_d = cell_data[0];
                for (int i = 0; i < CAPACITY - 1; i++) begin
                  cell_op[i] = CELL_TAKE_NEXT;
                end
                count_d = count_q - CntW'(1);
              end
            end
            MODE_POP_TAIL: begin
              valid_d = 1'b1;
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                value_d = cell_data[IdxW'(count_q - CntW'(1))];
                count_d = count_q - CntW'(1);
              end
            end
            MODE_DEL_KEY: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                // compare all cells now, resolve the first hit next cycle
                match_d = cell_match & occupied;
                key_d   = operand_value_i;
                state_d = ST_KEY;
              end
            end
            MODE_DUMP: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                dump_idx_d = '0;
                state_d    = ST_DUMP;
              end
            end
            default: ;  // unused codes: no result
          endcase
        end
      end

      ST_KEY: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
        if (match_q == '0) begin
          status_d = STAT_NOT_FOUND;
        end else begin
          value_d = key_q;  // the removed entry equals the key
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (shift_mask[i]) cell_op[i] = CELL_TAKE_NEXT;
          end
          count_d = count_q - CntW'(1);
        end
      end

      ST_DUMP: begin
        // emit the head, rotate the occupied cells by one
        valid_d = 1'b1;
        value_d = cell_data[0];
        for (int i = 0; i < CAPACITY; i++) begin
          if (CntW'(i + 1) < count_q)  cell_op[i] = CELL_TAKE_NEXT;
          if (CntW'(i + 1) == count_q) cell_op[i] = CELL_TAKE_HEAD;
        end
        last_d     = ((dump_idx_q + CntW'(1)) == count_q);
        dump_idx_d = dump_idx_q + CntW'(1);
        if (last_d) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      dump_idx_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dump_idx_q <= dump_idx_d;
      valid_q    <= valid_d;
    end
  end

  // result payload and search scratch, no reset
  always_ff @(posedge clk_i) begin
    match_q  <= match_d;
    key_q    <= key_d;
    status_q <= status_d;
    value_q  <= value_d;
    last_q   <= last_d;
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign entry_value_o  = value_q;
  assign last_flag_o    = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> result_valid_o)
    else $error("dump cycle without a result");

  a_mid_dump_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_flag_o) |-> (state_q == ST_DUMP))
    else $error("non-final result outside a dump");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && mode_i == MODE_APPEND && count_q != CntW'(CAPACITY))
      |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("append did not grow the list");
`endif

endmodule
